FILE: rtl/pcmfade_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfade_pkg
// Shared types, widths and codes of the linear fade-in / fade-out core.
// ----------------------------------------------------------------------------
package pcmfade_pkg;

  // Sample index width; position saturates at min(clip length, largest index).
  localparam int IDX_W     = 32;
  localparam int SAMPLE_W  = 16;
  localparam int FADE_W    = 18;
  localparam int TOTAL_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  // Width in which index, clip length and fade length are compared.
  localparam int CMP_W     = (IDX_W > TOTAL_W) ? IDX_W : TOTAL_W;
  localparam int PROD_W    = SAMPLE_W + FADE_W;
  // Quotient is below 2^SAMPLE_W, so the divider needs SAMPLE_W steps.
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CMP_W-1:0] IDX_MAX = CMP_W'({64{1'b1}} >> (64 - IDX_W));

  localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 17'sd32767;
  localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -17'sd32768;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bypass;
    logic div_last;
  } status_t;

endpackage

FILE: rtl/pcmfade_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfade_ctrl
// Sequencer: accept, classify, multiply, divide if faded, pass the result on.
// ----------------------------------------------------------------------------
module pcmfade_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pcmfade_pkg::status_t  status,
  output pcmfade_pkg::cmd_t     cmd
);

  pcmfade_pkg::state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcmfade_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcmfade_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pcmfade_pkg::ST_PREP;
      end
      pcmfade_pkg::ST_PREP: state_nxt = pcmfade_pkg::ST_MUL;
      pcmfade_pkg::ST_MUL: begin
        state_nxt = status.bypass ? pcmfade_pkg::ST_DONE : pcmfade_pkg::ST_DIV;
      end
      pcmfade_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = pcmfade_pkg::ST_DONE;
      end
      pcmfade_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = pcmfade_pkg::ST_IDLE;
      end
      default: state_nxt = pcmfade_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      pcmfade_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pcmfade_pkg::ST_PREP: cmd.prep = 1'b1;
      pcmfade_pkg::ST_MUL:  cmd.mul  = 1'b1;
      pcmfade_pkg::ST_DIV:  cmd.div_step = 1'b1;
      pcmfade_pkg::ST_DONE: cmd.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/pcmfade_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfade_dpath
// Configuration, sample position, gain selection, multiplier and divider.
// ----------------------------------------------------------------------------
module pcmfade_dpath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [pcmfade_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcmfade_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [pcmfade_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                    in_restart,
  input  pcmfade_pkg::cmd_t                       cmd,
  output pcmfade_pkg::status_t                    status,
  output logic signed [pcmfade_pkg::SAMPLE_W-1:0] out_sample_out
);

  localparam int SW = pcmfade_pkg::SAMPLE_W;
  localparam int FW = pcmfade_pkg::FADE_W;
  localparam int CW = pcmfade_pkg::CMP_W;
  localparam int IW = pcmfade_pkg::IDX_W;

  logic [FW-1:0]                   fade_r;
  logic [pcmfade_pkg::TOTAL_W-1:0] total_r;
  logic [IW-1:0]                   pos_r, pos_nxt;
  logic [IW-1:0]                   idx_r;
  logic signed [SW-1:0]            sample_r;
  logic [FW-1:0]                   k_r, k_nxt;
  logic                            bypass_r, bypass_nxt;
  logic [FW-1:0]                   rem_r;
  logic [SW-1:0]                   quo_r;
  logic [pcmfade_pkg::CNT_W-1:0]   cnt_r;
  logic signed [SW-1:0]            out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r  <= '0;
      total_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcmfade_pkg::REG_FADE_LENGTH:   fade_r  <= cfg_data[FW-1:0];
        pcmfade_pkg::REG_TOTAL_SAMPLES: total_r <= cfg_data[pcmfade_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Gain selection and position update
  logic [CW-1:0] idx_ext, tot_ext, fade_ext, idx_end, rem_end, lim;
  logic          in_fade, out_fade;

  always_comb begin
    idx_ext  = CW'(idx_r);
    tot_ext  = CW'(total_r);
    fade_ext = CW'(fade_r);
    in_fade  = idx_ext < fade_ext;
    idx_end  = (idx_ext > tot_ext) ? tot_ext : idx_ext;
    rem_end  = tot_ext - idx_end;
    out_fade = rem_end < fade_ext;
    k_nxt    = in_fade ? idx_ext[FW-1:0] : rem_end[FW-1:0];
    bypass_nxt = (fade_r == '0) || (!in_fade && !out_fade);
    lim      = (tot_ext < pcmfade_pkg::IDX_MAX) ? tot_ext : pcmfade_pkg::IDX_MAX;
    pos_nxt  = (idx_ext < lim) ? IW'(idx_ext + CW'(1)) : lim[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.prep) begin
      pos_r <= pos_nxt;
    end
  end

  // Magnitude times gain, then restoring division by the fade length
  logic [SW-1:0]                     mag;
  logic [pcmfade_pkg::PROD_W-1:0]    prod;
  logic [FW:0]                       trial, diff;
  logic                              ge;

  always_comb begin
    mag   = sample_r[SW-1] ? SW'(~sample_r + 1'b1) : SW'(sample_r);
    prod  = pcmfade_pkg::PROD_W'(mag) * pcmfade_pkg::PROD_W'(k_r);
    trial = {rem_r, quo_r[SW-1]};
    diff  = trial - {1'b0, fade_r};
    ge    = trial >= {1'b0, fade_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample_in;
      idx_r    <= in_restart ? '0 : pos_r;
    end
    if (cmd.prep) begin
      k_r      <= k_nxt;
      bypass_r <= bypass_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[pcmfade_pkg::PROD_W-1:SW];
      quo_r <= prod[SW-1:0];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[FW-1:0] : trial[FW-1:0];
      quo_r <= {quo_r[SW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Sign restore and clamp
  logic signed [SW:0] signed_q, clamped;

  always_comb begin
    signed_q = sample_r[SW-1] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (signed_q > pcmfade_pkg::SAMPLE_MAX)      clamped = pcmfade_pkg::SAMPLE_MAX;
    else if (signed_q < pcmfade_pkg::SAMPLE_MIN) clamped = pcmfade_pkg::SAMPLE_MIN;
    else                                         clamped = signed_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= bypass_r ? sample_r : clamped[SW-1:0];
    end
  end

  assign status.bypass   = bypass_r;
  assign status.div_last = (cnt_r == pcmfade_pkg::CNT_W'(pcmfade_pkg::DIV_STEPS - 1));
  assign out_sample_out  = out_r;

endmodule

FILE: rtl/pcm_linear_fade_in_out_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_linear_fade_in_out_core
// Linear fade-in / fade-out gain on a stream of signed 16-bit PCM words.
// ----------------------------------------------------------------------------
// Steps after input acceptance when faded: classify, multiply, 16 divider
//   steps, output load; when the word passes unchanged: classify, multiply,
//   output load. No new word is taken until the previous result is loaded
//   into the output register; the 16-step restoring divider sets the pace.
// Reset (rst_n low, synchronous) clears the position, both registers and the
//   controller; no result is held afterwards.
// ----------------------------------------------------------------------------
module pcm_linear_fade_in_out_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration write port
  input  logic                                    cfg_we,
  input  logic [pcmfade_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcmfade_pkg::CFG_W-1:0]           cfg_data,
  // input words
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [pcmfade_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                    in_restart,
  // result words
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pcmfade_pkg::SAMPLE_W-1:0] out_sample_out
);

  // The controller steps through accept, classify, multiply and, if faded,
  // divide; the result sits in an output register, so the next word may be
  // taken while the previous one still waits downstream. The controller
  // holds a finished word in its last state until the output register is free.
  pcmfade_pkg::cmd_t    cmd;
  pcmfade_pkg::status_t status;

  pcmfade_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath keeps the fade and clip lengths, the running position, the
  // gain selection, a 16x18 multiplier and a one-bit-a-cycle divider.
  pcmfade_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .status         (status),
    .out_sample_out (out_sample_out)
  );

endmodule
